### rtl/huffman_tree_walk_decoder_assert.svh
// assertion macros for the huffman tree walk decoder checker
`ifndef HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_WALK_DECODER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define HWD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define HWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hwd_pkg.sv
// shared types and constants of the huffman tree walk decoder
`timescale 1ns / 1ps

package hwd_pkg;

  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int ACT_W          = 2;
  localparam int LEN_W          = 32;
  localparam int BYTE_W         = 8;
  localparam int BIT_CNT_W      = 4;
  localparam int NODE_COUNT_DEF = 511;

  localparam logic [BIT_CNT_W-1:0] BYTE_BITS = BIT_CNT_W'(BYTE_W);

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_DATA    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             status;
    logic             stream_done;
    logic             last;
  } result_t;

endpackage

### rtl/hwd_node_mem.sv
// code tree node table, one write port and one registered read port
`timescale 1ns / 1ps

module hwd_node_mem #(
  parameter int NODE_COUNT = hwd_pkg::NODE_COUNT_DEF,
  localparam int AW = $clog2(NODE_COUNT)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  hwd_pkg::node_t wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output hwd_pkg::node_t rd_data
);

  hwd_pkg::node_t mem_r [NODE_COUNT];
  hwd_pkg::node_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/hwd_bit_walker.sv
// request sequencer and bit-serial tree walk over the node table
`timescale 1ns / 1ps

module hwd_bit_walker #(
  parameter int NODE_COUNT = hwd_pkg::NODE_COUNT_DEF,
  localparam int AW = $clog2(NODE_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  input  logic [hwd_pkg::ACT_W-1:0]   action,
  input  logic [hwd_pkg::IDX_W-1:0]   node_index,
  input  logic                        leaf_flag,
  input  logic [hwd_pkg::SYM_W-1:0]   node_symbol,
  input  logic [hwd_pkg::IDX_W-1:0]   left_index,
  input  logic [hwd_pkg::IDX_W-1:0]   right_index,
  input  logic [hwd_pkg::BYTE_W-1:0]  data_byte,
  input  logic [hwd_pkg::LEN_W-1:0]   stream_length,
  output logic                        busy,
  input  logic                        out_free,
  output logic                        push,
  output hwd_pkg::result_t            push_res,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output hwd_pkg::node_t              wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  hwd_pkg::node_t              rd_data
);

  localparam int CW = (AW > hwd_pkg::IDX_W) ? AW : hwd_pkg::IDX_W;
  localparam logic [CW-1:0] NODE_LIMIT = CW'(NODE_COUNT);

  hwd_pkg::state_t                  state_r, state_nxt;
  logic [hwd_pkg::BYTE_W-1:0]       shreg_r, shreg_nxt;
  logic [hwd_pkg::BIT_CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic                             pending_r, pending_nxt;
  logic [hwd_pkg::IDX_W-1:0]        walk_pos_r, walk_pos_nxt;
  logic [hwd_pkg::LEN_W-1:0]        count_r, count_nxt;
  logic                             err_seen_r, err_seen_nxt;
  hwd_pkg::result_t                 hold_r, hold_nxt;
  logic                             hold_valid_r, hold_valid_nxt;

  logic [hwd_pkg::IDX_W-1:0]        next_idx;
  logic                             next_ok;
  logic                             slot_ok;
  logic                             done_now;
  hwd_pkg::result_t                 err_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hwd_pkg::ST_IDLE;
      walk_pos_r   <= '0;
      count_r      <= '0;
      err_seen_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      pending_r    <= 1'b0;
      bit_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      walk_pos_r   <= walk_pos_nxt;
      count_r      <= count_nxt;
      err_seen_r   <= err_seen_nxt;
      hold_valid_r <= hold_valid_nxt;
      pending_r    <= pending_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
    hold_r  <= hold_nxt;
  end

  // the top bit of the shift register picks the child
  assign next_idx = shreg_r[hwd_pkg::BYTE_W-1] ? rd_data.right : rd_data.left;
  assign next_ok  = CW'(next_idx) < NODE_LIMIT;
  // a new result may displace the held one only if the output register can take it
  assign slot_ok  = !hold_valid_r || out_free;
  assign done_now = (count_r + hwd_pkg::LEN_W'(1)) == stream_length;
  assign busy     = (state_r != hwd_pkg::ST_IDLE);

  always_comb begin
    err_res             = '0;
    err_res.status      = hwd_pkg::STAT_ERR;

    state_nxt      = state_r;
    shreg_nxt      = shreg_r;
    bit_cnt_nxt    = bit_cnt_r;
    pending_nxt    = pending_r;
    walk_pos_nxt   = walk_pos_r;
    count_nxt      = count_r;
    err_seen_nxt   = err_seen_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;

    push     = 1'b0;
    push_res = hold_r;
    wr_en    = 1'b0;
    wr_addr  = AW'(node_index);
    wr_data  = '{leaf: leaf_flag, symbol: node_symbol, left: left_index,
                 right: right_index};
    rd_en    = 1'b0;
    rd_addr  = '0;

    unique case (state_r)
      hwd_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (hwd_pkg::action_t'(action))
            hwd_pkg::ACT_WRITE: begin
              wr_en = (CW'(node_index) < NODE_LIMIT);
            end
            hwd_pkg::ACT_DATA: begin
              if (count_r >= stream_length) begin
                // stream complete, byte ignored
              end else if (err_seen_r) begin
                hold_nxt       = err_res;
                hold_valid_nxt = 1'b1;
                state_nxt      = hwd_pkg::ST_FLUSH;
              end else begin
                shreg_nxt   = data_byte;
                bit_cnt_nxt = '0;
                state_nxt   = hwd_pkg::ST_FETCH;
              end
            end
            hwd_pkg::ACT_RESTART: begin
              walk_pos_nxt = '0;
              count_nxt    = '0;
              err_seen_nxt = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      hwd_pkg::ST_FETCH: begin
        rd_en       = 1'b1;
        rd_addr     = AW'(walk_pos_r);
        pending_nxt = 1'b0;
        state_nxt   = hwd_pkg::ST_WALK;
      end

      hwd_pkg::ST_WALK: begin
        if (pending_r && rd_data.leaf) begin
          // child just fetched is a leaf: emit and restart from the root
          if (slot_ok) begin
            push                 = hold_valid_r;
            hold_nxt             = '0;
            hold_nxt.symbol      = rd_data.symbol;
            hold_nxt.status      = hwd_pkg::STAT_OK;
            hold_nxt.stream_done = done_now;
            hold_valid_nxt       = 1'b1;
            count_nxt            = count_r + hwd_pkg::LEN_W'(1);
            walk_pos_nxt         = '0;
            rd_en                = 1'b1;
            rd_addr              = '0;
            pending_nxt          = 1'b0;
            if (done_now) begin
              state_nxt = hwd_pkg::ST_FLUSH;
            end
          end
        end else if (bit_cnt_r == hwd_pkg::BYTE_BITS) begin
          state_nxt = hwd_pkg::ST_FLUSH;
        end else if (!rd_data.leaf && next_ok) begin
          rd_en        = 1'b1;
          rd_addr      = AW'(next_idx);
          walk_pos_nxt = next_idx;
          pending_nxt  = 1'b1;
          shreg_nxt    = {shreg_r[hwd_pkg::BYTE_W-2:0], 1'b0};
          bit_cnt_nxt  = bit_cnt_r + hwd_pkg::BIT_CNT_W'(1);
        end else if (slot_ok) begin
          // stepping from a leaf or to a child outside the table
          push           = hold_valid_r;
          hold_nxt       = err_res;
          hold_valid_nxt = 1'b1;
          err_seen_nxt   = 1'b1;
          state_nxt      = hwd_pkg::ST_FLUSH;
        end
      end

      hwd_pkg::ST_FLUSH: begin
        push_res.last = 1'b1;
        if (!hold_valid_r) begin
          state_nxt = hwd_pkg::ST_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = hwd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = hwd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/huffman_tree_walk_decoder.sv
// Huffman decoder that walks a stored code tree one bit per cycle, apart from a root
// reload after each decoded symbol and while the output stalls. Requests are node
// writes (nodes outside NODE_COUNT dropped), stream restarts and compressed bytes.
// A byte is taken, the node the walk stands on is read, then come eight bit steps
// with a root reload for each decoded symbol, a check that finds the byte used up
// and the hand-over of its last result. A byte that completes the stream or hits an
// error goes straight to that hand-over, a byte after the stream is complete is
// ignored, and a stalled output can hold the walk, and so the input, until it frees.
// Each bit step is one dependent read of the node table's single read port. Results
// leave through an output register, so the next request is taken while the last
// result waits. Nodes never written read as garbage. A step from a leaf or to a
// child outside the table gives an error result and a sticky error until the next
// restart.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT = hwd_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hwd_pkg::LEN_W-1:0]   cfg_stream_length,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hwd_pkg::ACT_W-1:0]   in_action,
  input  logic [hwd_pkg::IDX_W-1:0]   in_node_index,
  input  logic                        in_leaf_flag,
  input  logic [hwd_pkg::SYM_W-1:0]   in_node_symbol,
  input  logic [hwd_pkg::IDX_W-1:0]   in_left_index,
  input  logic [hwd_pkg::IDX_W-1:0]   in_right_index,
  input  logic [hwd_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hwd_pkg::SYM_W-1:0]   out_symbol,
  output logic                        out_status,
  output logic                        out_stream_done,
  output logic                        out_last
);

  localparam int AW = $clog2(NODE_COUNT);

  logic [hwd_pkg::LEN_W-1:0] stream_length_r;
  logic                      out_valid_r;
  hwd_pkg::result_t          out_res_r;

  logic                      busy;
  logic                      in_fire;
  logic                      out_free;
  logic                      push;
  hwd_pkg::result_t          push_res;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  hwd_pkg::node_t            wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  hwd_pkg::node_t            rd_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      stream_length_r <= cfg_stream_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= push_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_res_r.symbol;
  assign out_status      = out_res_r.status;
  assign out_stream_done = out_res_r.stream_done;
  assign out_last        = out_res_r.last;

  hwd_node_mem #(
    .NODE_COUNT (NODE_COUNT)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hwd_bit_walker #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .action        (in_action),
    .node_index    (in_node_index),
    .leaf_flag     (in_leaf_flag),
    .node_symbol   (in_node_symbol),
    .left_index    (in_left_index),
    .right_index   (in_right_index),
    .data_byte     (in_data_byte),
    .stream_length (stream_length_r),
    .busy          (busy),
    .out_free      (out_free),
    .push          (push),
    .push_res      (push_res),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

endmodule

### rtl/hwd_checker.sv
// port-level checks on the decoder's result channel, bound to the top level
`timescale 1ns / 1ps
`include "huffman_tree_walk_decoder_assert.svh"

module hwd_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [hwd_pkg::SYM_W-1:0] out_symbol,
  input logic                      out_status,
  input logic                      out_stream_done,
  input logic                      out_last
);

  // a stalled result stays put
  `HWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_symbol) && $stable(out_status) && $stable(out_last), "stalled result changed")

  // error results carry no symbol and never complete the stream
  `HWD_ASSERT_IMPLY(a_err_clean, out_valid && out_status == hwd_pkg::STAT_ERR, out_symbol == '0 && !out_stream_done, "error result with symbol or done")

  // an error ends the request's results
  `HWD_ASSERT_IMPLY(a_err_last, out_valid && out_status == hwd_pkg::STAT_ERR, out_last, "error result not last")

  // completing the stream ends the request's results
  `HWD_ASSERT_IMPLY(a_done_last, out_valid && out_stream_done, out_last && out_status == hwd_pkg::STAT_OK, "stream done not on last ok result")

endmodule

bind huffman_tree_walk_decoder hwd_checker u_hwd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_symbol      (out_symbol),
  .out_status      (out_status),
  .out_stream_done (out_stream_done),
  .out_last        (out_last)
);

### bench/testbench.sv
// self-checking testbench for the huffman tree walk decoder
`timescale 1ns / 1ps

module testbench;
  import hwd_pkg::*;

  localparam int NODES       = NODE_COUNT_DEF;
  localparam int MAX_GAP     = 11;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 250;
  localparam int MAX_LEAVES  = 40;
  localparam int LIMIT_NS    = 2_000_000;

  localparam logic [IDX_W-1:0] OUT_OF_TABLE = IDX_W'(NODES);
  localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  node_index;
    logic              leaf;
    logic [SYM_W-1:0]  symbol;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
    logic [BYTE_W-1:0] data;
  } request_t;

  // mirrors the decoder state and queues the symbols each request should produce
  class symbol_board;
    node_t            tree [NODES];
    logic [IDX_W-1:0] walk;
    logic [LEN_W-1:0] decoded;
    logic [LEN_W-1:0] length;
    bit               broken;
    result_t          pending [$];
    int               mismatches;

    function new();
      for (int i = 0; i < NODES; i++) tree[i] = '0;
      walk = '0;
      decoded = '0;
      length = '0;
      broken = 0;
      mismatches = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] value);
      length = value;
    endfunction

    function void push_error();
      result_t e;
      e.symbol = '0;
      e.status = STAT_ERR;
      e.stream_done = 1'b0;
      e.last = 1'b0;
      pending.push_back(e);
      broken = 1;
    endfunction

    function void note_request(request_t r);
      node_t            cur;
      node_t            nxt;
      logic [IDX_W-1:0] child;
      result_t          res;
      int               first;
      first = pending.size();
      case (r.action)
        ACT_WRITE: begin
          if (r.node_index < OUT_OF_TABLE)
            tree[r.node_index] = {r.leaf, r.symbol, r.left, r.right};
        end
        ACT_RESTART: begin
          walk = '0;
          decoded = '0;
          broken = 0;
        end
        ACT_DATA: begin
          if (decoded < length) begin
            if (broken) begin
              push_error();
            end else begin
              for (int i = BYTE_W - 1; i >= 0; i--) begin
                if (decoded >= length) break;
                cur = tree[walk];
                if (cur.leaf) begin
                  push_error();
                  break;
                end
                child = r.data[i] ? cur.right : cur.left;
                if (child >= OUT_OF_TABLE) begin
                  push_error();
                  break;
                end
                nxt = tree[child];
                if (nxt.leaf) begin
                  decoded++;
                  res.symbol = nxt.symbol;
                  res.status = STAT_OK;
                  res.stream_done = (decoded == length);
                  res.last = 1'b0;
                  pending.push_back(res);
                  walk = '0;
                end else begin
                  walk = child;
                end
              end
            end
            if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_symbol(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: symbol %02h status %0b done %0b last %0b",
                   got.symbol, got.status, got.stream_done, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("result mismatch: expected symbol %02h status %0b done %0b last %0b, ",
                 want.symbol, want.status, want.stream_done, want.last);
          $display("got symbol %02h status %0b done %0b last %0b",
                   got.symbol, got.status, got.stream_done, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [LEN_W-1:0] cfg_stream_length;
  logic in_valid;
  logic in_stall;
  logic [ACT_W-1:0] in_action;
  logic [IDX_W-1:0] in_node_index;
  logic in_leaf_flag;
  logic [SYM_W-1:0] in_node_symbol;
  logic [IDX_W-1:0] in_left_index;
  logic [IDX_W-1:0] in_right_index;
  logic [BYTE_W-1:0] in_data_byte;
  logic out_valid;
  logic out_stall;
  logic [SYM_W-1:0] out_symbol;
  logic out_status;
  logic out_stream_done;
  logic out_last;

  symbol_board board;
  bit written [NODES];
  bit idle_in;
  bit idle_out;
  bit hold_request;

  huffman_tree_walk_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_stream_length (cfg_stream_length),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_node_index     (in_node_index),
    .in_leaf_flag      (in_leaf_flag),
    .in_node_symbol    (in_node_symbol),
    .in_left_index     (in_left_index),
    .in_right_index    (in_right_index),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_symbol        (out_symbol),
    .out_status        (out_status),
    .out_stream_done   (out_stream_done),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  task automatic push_request(request_t r);
    int gap;
    gap = idle_in ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= r.action;
    in_node_index  <= r.node_index;
    in_leaf_flag   <= r.leaf;
    in_node_symbol <= r.symbol;
    in_left_index  <= r.left;
    in_right_index <= r.right;
    in_data_byte   <= r.data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(r);
    if (r.action == ACT_WRITE && r.node_index < OUT_OF_TABLE) written[r.node_index] = 1;
  endtask

  // unused fields carry random values so that every payload bit toggles
  function automatic request_t random_request(logic [ACT_W-1:0] action);
    request_t r;
    r.action     = action;
    r.node_index = IDX_W'($urandom_range(0, 511));
    r.leaf       = 1'($urandom_range(0, 1));
    r.symbol     = SYM_W'($urandom_range(0, 255));
    r.left       = IDX_W'($urandom_range(0, 511));
    r.right      = IDX_W'($urandom_range(0, 511));
    r.data       = BYTE_W'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic send_write(logic [IDX_W-1:0] idx, logic leaf, logic [SYM_W-1:0] sym,
                            logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
    request_t req;
    req = random_request(ACT_WRITE);
    req.node_index = idx;
    req.leaf = leaf;
    req.symbol = sym;
    req.left = l;
    req.right = r;
    push_request(req);
  endtask

  task automatic send_data(logic [BYTE_W-1:0] value);
    request_t req;
    req = random_request(ACT_DATA);
    req.data = value;
    push_request(req);
  endtask

  task automatic send_ctrl(logic [ACT_W-1:0] action);
    push_request(random_request(action));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(logic [LEN_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_stream_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_length(value);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_written();
    int v;
    do v = $urandom_range(0, NODES - 1); while (!written[v]);
    return IDX_W'(v);
  endfunction

  // random full binary tree rooted at node 0, inner nodes only point at nodes of the
  // same tree, or off the table for bad_child, so no walk reads an unwritten entry
  task automatic build_tree(int leaves, bit bad_child);
    int tab [2*MAX_LEAVES];
    bit inner [2*MAX_LEAVES];
    int lk [2*MAX_LEAVES];
    int rk [2*MAX_LEAVES];
    int ord [2*MAX_LEAVES];
    bit taken [NODES];
    int open [$];
    int n, k, p, j, t, pick, bad_node;
    n = 1;
    tab[0] = 0;
    inner[0] = 0;
    taken[0] = 1;
    open.push_back(0);
    while (open.size() < leaves) begin
      k = $urandom_range(0, open.size() - 1);
      p = open[k];
      open.delete(k);
      inner[p] = 1;
      lk[p] = n;
      rk[p] = n + 1;
      repeat (2) begin
        do pick = $urandom_range(1, NODES - 1); while (taken[pick]);
        taken[pick] = 1;
        tab[n] = pick;
        inner[n] = 0;
        open.push_back(n);
        n++;
      end
    end
    bad_node = -1;
    if (bad_child && n > 1) begin
      do bad_node = $urandom_range(0, n - 1); while (!inner[bad_node]);
    end
    for (int i = 0; i < n; i++) ord[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ord[i];
      ord[i] = ord[j];
      ord[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      p = ord[i];
      if (inner[p])
        send_write(IDX_W'(tab[p]), 1'b0, SYM_W'($urandom_range(0, 255)), IDX_W'(tab[lk[p]]),
                   p == bad_node ? OUT_OF_TABLE : IDX_W'(tab[rk[p]]));
      else
        send_write(IDX_W'(tab[p]), 1'b1, SYM_W'($urandom_range(0, 255)),
                   IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)));
    end
  endtask

  // rewrite a live node while a walk may be standing on it
  task automatic stray_write();
    logic [IDX_W-1:0] node;
    logic [IDX_W-1:0] l;
    logic [IDX_W-1:0] r;
    node = pick_written();
    if ($urandom_range(0, 3) == 0) begin
      send_write(node, 1'b1, SYM_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 511)),
                 IDX_W'($urandom_range(0, 511)));
    end else begin
      l = ($urandom_range(0, 9) == 0) ? OUT_OF_TABLE : pick_written();
      r = ($urandom_range(0, 9) == 0) ? OUT_OF_TABLE : pick_written();
      send_write(node, 1'b0, SYM_W'($urandom_range(0, 255)), l, r);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_symbol(result_t'({out_symbol, out_status, out_stream_done, out_last}));
  end

  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      hold = idle_out ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int phase;
    int random_items;
    int n_items;
    int kind;
    int leaves;
    logic [LEN_W-1:0] len;
    board = new();
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_stream_length <= '0;
    in_valid <= 1'b0;
    in_action <= '0;
    in_node_index <= '0;
    in_leaf_flag <= 1'b0;
    in_node_symbol <= '0;
    in_left_index <= '0;
    in_right_index <= '0;
    in_data_byte <= '0;
    idle_in = 0;
    idle_out = 0;
    hold_request = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // two-leaf tree, every bit decodes a symbol
    write_length('1);
    send_write(9'd1, 1'b1, 8'h00, OUT_OF_TABLE, OUT_OF_TABLE);
    send_write(9'd2, 1'b1, 8'hff, 9'd0, 9'd0);
    send_write(9'd0, 1'b0, 8'h00, 9'd1, 9'd2);
    send_write(OUT_OF_TABLE, 1'b1, 8'haa, 9'd0, 9'd0);
    send_ctrl(ACT_UNUSED);
    send_ctrl(ACT_RESTART);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'ha5);
    // deeper left branch, byte ends part way down it
    send_write(9'd3, 1'b0, 8'h00, 9'd1, 9'd2);
    send_write(9'd0, 1'b0, 8'h00, 9'd3, 9'd2);
    send_data(8'h5a);
    // node under the walk becomes a leaf, then the error sticks
    send_write(9'd3, 1'b1, 8'h3c, OUT_OF_TABLE, 9'd0);
    send_data(8'h80);
    send_data(8'h00);
    send_ctrl(ACT_RESTART);
    // right child off the end of the table
    send_write(9'd0, 1'b0, 8'h00, 9'd1, OUT_OF_TABLE);
    send_data(8'h01);
    send_ctrl(ACT_RESTART);
    // root on its own is a leaf
    send_write(9'd0, 1'b1, 8'h42, 9'd1, 9'd2);
    send_data(8'h00);
    send_write(9'd0, 1'b0, 8'h00, 9'd1, 9'd2);
    send_ctrl(ACT_RESTART);
    // zero length ignores data, short stream stops mid byte
    write_length('0);
    send_data(8'hff);
    write_length(32'd5);
    send_ctrl(ACT_RESTART);
    send_data(8'h00);
    send_data(8'hff);

    random_items = 0;
    phase = 0;
    while (random_items < 64) begin
      idle_in = $urandom_range(0, 3) != 0;
      idle_out = $urandom_range(0, 3) != 0;
      if (phase == 1) begin
        // receiver holds off while bytes keep coming, so the input backs up
        idle_in = 0;
        write_length('1);
        build_tree(2, 0);
        send_ctrl(ACT_RESTART);
        hold_request = 1;
        repeat (12) send_data(BYTE_W'($urandom_range(0, 255)));
        random_items += 16;
      end else begin
        if (phase == 0 || $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = 32'd1;
            2:       len = '1;
            3:       len = $urandom;
            default: len = $urandom_range(2, 40);
          endcase
          write_length(len);
        end
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 9))
            0:       leaves = 1;
            1:       leaves = $urandom_range(20, MAX_LEAVES);
            default: leaves = $urandom_range(2, 8);
          endcase
          build_tree(leaves, $urandom_range(0, 5) == 0);
          random_items += 2 * leaves - 1;
        end
        send_ctrl(ACT_RESTART);
        n_items = $urandom_range(4, 12);
        for (int i = 0; i < n_items; i++) begin
          kind = $urandom_range(0, 19);
          if (phase == 2 && i == 2) wait_drained();
          case (kind)
            0: stray_write();
            1: send_ctrl(ACT_UNUSED);
            2: send_write(OUT_OF_TABLE, 1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                          IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)));
            3: send_ctrl(ACT_RESTART);
            4: begin
              wait_drained();
              send_data(BYTE_W'($urandom_range(0, 255)));
            end
            default: send_data(BYTE_W'($urandom_range(0, 255)));
          endcase
          if (kind != 1 && kind != 2) random_items++;
        end
      end
      phase++;
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/hwd_pkg.sv
rtl/hwd_node_mem.sv
rtl/hwd_bit_walker.sv
rtl/huffman_tree_walk_decoder.sv
rtl/hwd_checker.sv
bench/testbench.sv
